// ===== hw/rtl/lcdseq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdseq_pkg - shared types and constants of the lcd nibble sequencer
// command codes, wait times, queue entry layout and the fixed write table
// ---------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

   // request modes
   typedef enum logic [2:0] {
      MODE_INIT   = 3'd0,
      MODE_CLEAR  = 3'd1,
      MODE_SEND   = 3'd2,
      MODE_GOTO   = 3'd3,
      MODE_NUMBER = 3'd4,
      MODE_BLINK  = 3'd5,
      MODE_STEADY = 3'd6
   } mode_type;

   // front state machine
   typedef enum logic [1:0] {
      FS_IDLE,
      FS_EMIT,
      FS_DIVIDE,
      FS_DIGITS
   } front_state_type;

   // display command bytes
   localparam logic [7:0] CMD_FUNC_SET      = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON    = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE    = 8'h06;
   localparam logic [7:0] CMD_CLEAR         = 8'h01;
   localparam logic [7:0] CMD_CURSOR_BLINK  = 8'h0F;
   localparam logic [7:0] CMD_CURSOR_STEADY = 8'h0E;
   localparam logic [7:0] LINE0_ADDR        = 8'h80;
   localparam logic [7:0] LINE1_ADDR        = 8'hC0;
   localparam logic [7:0] ASCII_ZERO        = 8'd48;

   // init wake-up nibbles
   localparam logic [7:0] WAKE_NIB_8BIT = 8'h03;
   localparam logic [7:0] WAKE_NIB_4BIT = 8'h02;

   // wait times in microseconds
   localparam logic [14:0] HOLD_US     = 15'd50;
   localparam logic [14:0] WAKE1_US    = 15'd51;
   localparam logic [14:0] WAKE2_US    = 15'd55;
   localparam logic [14:0] LONG_US     = 15'd5050;
   localparam logic [14:0] POWER_UP_US = 15'd20000;
   localparam logic [9:0]  GOTO_PRE_US = 10'd1000;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // one queue entry: a byte write (two nibbles) or a single nibble write
   typedef struct packed {
      logic        single;
      logic        strobe;
      logic [7:0]  value;
      logic        rs;
      logic        pre_long;
      logic [14:0] post_hi;
      logic [14:0] post_lo;
      logic        last;
   } op_type;

   // number of queue entries for fixed-sequence modes
   function automatic logic [2:0] op_count(input logic [2:0] mode);
      logic [2:0] n;
      case (mode)
         MODE_INIT:   n = 3'd7;
         MODE_CLEAR:  n = 3'd1;
         MODE_SEND:   n = 3'd1;
         MODE_GOTO:   n = 3'd1;
         MODE_BLINK:  n = 3'd2;
         MODE_STEADY: n = 3'd2;
         default:     n = 3'd0;
      endcase
      return n;
   endfunction

   // entry at a given step of a fixed-sequence mode, last flag left clear
   function automatic op_type fixed_op(input logic [2:0] mode, input logic [2:0] step,
                                       input logic [7:0] byte_value, input logic reg_select,
                                       input logic [3:0] column, input logic row);
      op_type     op;
      logic [7:0] addr;
      addr       = (row ? LINE1_ADDR : LINE0_ADDR) + {4'b0000, column};
      op         = '0;
      op.strobe  = 1'b1;
      op.post_hi = HOLD_US;
      op.post_lo = HOLD_US;
      case (mode)
         MODE_INIT: begin
            case (step)
               3'd0: begin
                  op.single  = 1'b1;
                  op.strobe  = 1'b0;
                  op.post_lo = POWER_UP_US;
               end
               3'd1: begin
                  op.single  = 1'b1;
                  op.value   = WAKE_NIB_8BIT;
                  op.post_lo = WAKE1_US;
               end
               3'd2: begin
                  op.single  = 1'b1;
                  op.value   = WAKE_NIB_4BIT;
                  op.post_lo = WAKE2_US;
               end
               3'd3: op.value = CMD_FUNC_SET;
               3'd4: op.value = CMD_DISPLAY_ON;
               3'd5: begin
                  op.value   = CMD_CLEAR;
                  op.post_lo = LONG_US;
               end
               default: op.value = CMD_ENTRY_MODE;
            endcase
         end
         MODE_CLEAR: begin
            op.value   = CMD_CLEAR;
            op.post_lo = LONG_US;
         end
         MODE_SEND: begin
            op.value = byte_value;
            op.rs    = reg_select;
         end
         MODE_GOTO, MODE_BLINK, MODE_STEADY: begin
            if (step == 3'd0) begin
               op.value    = addr;
               op.pre_long = 1'b1;
               op.post_lo  = LONG_US;
            end else if (mode == MODE_BLINK) begin
               op.value = CMD_CURSOR_BLINK;
            end else begin
               op.value = CMD_CURSOR_STEADY;
            end
         end
         default: op = '0;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcdseq_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdseq_fifo - write queue between front and back
// short register queue of byte and nibble writes with fill count
// ---------------------------------------------------------------------------
`default_nettype none

module lcdseq_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  lcdseq_pkg::op_type   push_op,
   output logic                 full,
   input  wire                  pop,
   output lcdseq_pkg::op_type   head_op,
   output logic                 empty
);

   localparam int AW = lcdseq_pkg::QUEUE_AW;
   localparam int DEPTH = lcdseq_pkg::QUEUE_DEPTH;

   lcdseq_pkg::op_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   // status
   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head_op = mem_ff[rd_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // pointer and count update
   always_comb begin
      wr_in  = do_push ? wr_ff + AW'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lcdseq_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdseq_front - request intake and classification
// latches a request, expands fixed modes into queue entries and converts
// numbers to decimal digits one per cycle before queuing them
// ---------------------------------------------------------------------------
`default_nettype none

module lcdseq_front #(
   parameter int MAX_DIGITS = 10
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [3:0]           req_tuser,
   input  wire  [55:0]          req_tdata,
   output logic                 push,
   output lcdseq_pkg::op_type   push_op,
   input  wire                  full
);

   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int DW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   lcdseq_pkg::front_state_type state_ff, state_in;
   logic [2:0]  mode_ff;
   logic [7:0]  byte_ff;
   logic        rsel_ff;
   logic [3:0]  col_ff;
   logic        row_ff;
   logic [31:0] num_ff, num_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0]  step_ff, step_in;
   logic [2:0]  ops_ff, ops_in;
   logic [3:0]  digit_ff [MAX_DIGITS];
   logic        accept, dig_wr;

   logic [2:0]  in_mode;
   logic [3:0]  in_digits;
   logic [CW-1:0] in_sat;
   logic [63:0] prod;
   logic [31:0] quot;
   logic [31:0] rem;

   assign in_mode   = req_tuser[2:0];
   assign in_digits = req_tdata[48:45];
   assign in_sat    = (in_digits > 4'(MAX_DIGITS)) ? CW'(MAX_DIGITS) : CW'(in_digits);
   assign accept    = req_tvalid & req_tready;

   // divide by ten through the reciprocal, remainder by shift and subtract
   assign prod = {32'd0, num_ff} * 64'h00000000CCCCCCCD;
   assign quot = 32'(prod[63:35]);
   assign rem  = num_ff - {quot[28:0], 3'b000} - {quot[30:0], 1'b0};

   // next state and queue push
   always_comb begin
      state_in   = state_ff;
      num_in     = num_ff;
      dcnt_in    = dcnt_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      ops_in     = ops_ff;
      req_tready = 1'b0;
      push       = 1'b0;
      push_op    = '0;
      dig_wr     = 1'b0;
      case (state_ff)
         lcdseq_pkg::FS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               num_in  = req_tdata[44:13];
               dcnt_in = in_sat;
               cnt_in  = '0;
               step_in = '0;
               ops_in  = lcdseq_pkg::op_count(in_mode);
               if (in_mode == lcdseq_pkg::MODE_NUMBER) begin
                  if (in_sat != '0) begin
                     state_in = lcdseq_pkg::FS_DIVIDE;
                  end
               end else if (ops_in != 3'd0) begin
                  state_in = lcdseq_pkg::FS_EMIT;
               end
            end
         end
         lcdseq_pkg::FS_EMIT: begin
            push    = 1'b1;
            push_op = lcdseq_pkg::fixed_op(mode_ff, step_ff, byte_ff, rsel_ff, col_ff, row_ff);
            push_op.last = (step_ff == ops_ff - 3'd1);
            if (!full) begin
               step_in = step_ff + 3'd1;
               if (push_op.last) begin
                  state_in = lcdseq_pkg::FS_IDLE;
               end
            end
         end
         lcdseq_pkg::FS_DIVIDE: begin
            dig_wr = 1'b1;
            num_in = quot;
            if (cnt_ff == dcnt_ff - CW'(1)) begin
               state_in = lcdseq_pkg::FS_DIGITS;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         lcdseq_pkg::FS_DIGITS: begin
            push            = 1'b1;
            push_op.strobe  = 1'b1;
            push_op.value   = lcdseq_pkg::ASCII_ZERO + {4'b0000, digit_ff[cnt_ff[DW-1:0]]};
            push_op.rs      = 1'b1;
            push_op.post_hi = lcdseq_pkg::HOLD_US;
            push_op.post_lo = lcdseq_pkg::HOLD_US;
            push_op.last    = (cnt_ff == '0);
            if (!full) begin
               if (push_op.last) begin
                  state_in = lcdseq_pkg::FS_IDLE;
               end else begin
                  cnt_in = cnt_ff - CW'(1);
               end
            end
         end
         default: state_in = lcdseq_pkg::FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcdseq_pkg::FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request fields and work counters
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      dcnt_ff <= dcnt_in;
      cnt_ff  <= cnt_in;
      step_ff <= step_in;
      ops_ff  <= ops_in;
      if (accept) begin
         mode_ff <= in_mode;
         rsel_ff <= req_tuser[3];
         byte_ff <= req_tdata[7:0];
         col_ff  <= req_tdata[11:8];
         row_ff  <= req_tdata[12];
      end
   end

   // digit store, least significant digit at index zero
   always_ff @(posedge clock) begin
      if (dig_wr) begin
         digit_ff[cnt_ff[DW-1:0]] <= rem[3:0];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lcdseq_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcdseq_back - nibble splitter and result register
// takes queue entries and drives one nibble per free output slot
// ---------------------------------------------------------------------------
`default_nettype none

module lcdseq_back (
   input  wire                  clock,
   input  wire                  reset,
   input  lcdseq_pkg::op_type   head_op,
   input  wire                  empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);

   logic        valid_ff, valid_in;
   logic        half_ff, half_in;
   logic [3:0]  nib_ff, nib_in;
   logic        strobe_ff, strobe_in;
   logic [9:0]  pre_ff, pre_in;
   logic [14:0] post_ff, post_in;
   logic        rs_ff, rs_in;
   logic        last_ff, last_in;
   logic        slot_free, take;

   assign slot_free = ~valid_ff | rsp_tready;
   assign take      = slot_free & ~empty;

   // nibble selection from the head entry
   always_comb begin
      valid_in  = valid_ff;
      half_in   = half_ff;
      nib_in    = nib_ff;
      strobe_in = strobe_ff;
      pre_in    = pre_ff;
      post_in   = post_ff;
      rs_in     = rs_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (slot_free) begin
         valid_in = ~empty;
      end
      if (take) begin
         rs_in = head_op.rs;
         if (head_op.single) begin
            nib_in    = head_op.value[3:0];
            strobe_in = head_op.strobe;
            pre_in    = '0;
            post_in   = head_op.post_lo;
            last_in   = head_op.last;
            pop       = 1'b1;
         end else if (!half_ff) begin
            nib_in    = head_op.value[7:4];
            strobe_in = 1'b1;
            pre_in    = head_op.pre_long ? lcdseq_pkg::GOTO_PRE_US : 10'd0;
            post_in   = head_op.post_hi;
            last_in   = 1'b0;
            half_in   = 1'b1;
         end else begin
            nib_in    = head_op.value[3:0];
            strobe_in = 1'b1;
            pre_in    = '0;
            post_in   = head_op.post_lo;
            last_in   = head_op.last;
            half_in   = 1'b0;
            pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      nib_ff    <= nib_in;
      strobe_ff <= strobe_in;
      pre_ff    <= pre_in;
      post_ff   <= post_in;
      rs_ff     <= rs_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, post_ff, pre_ff, strobe_ff, nib_ff};
   assign rsp_tuser  = rs_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/char_lcd_nibble_command_sequencer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_nibble_command_sequencer_core - 4-bit character lcd sequencer
// turns one display request into the ordered nibble writes with timing
// ---------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  req_     in         tvalid / tready     tdata 56 bits, tuser 4 bits
//  rsp_     out        tvalid / tready     tdata 32 bits, tuser 1, tlast
//
// a request is taken when the front is idle; fixed modes queue one entry
// per cycle while the queue is not full, number mode first divides by ten
// once per digit, then queues one entry per digit. the back drives one
// nibble per cycle from a four-entry queue while the queue holds entries
// and the result is taken; the first nibble passes the front state register,
// the queue and the output register, numbers first pass the divider, and
// a request has up to 20 nibbles. reset is synchronous and clears the
// queue, the front state machine and the output register. a stalled
// result holds while the front keeps filling the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_command_sequencer_core #(
   parameter int MAX_DIGITS = 10
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // mode[2:0], reg_select[3]
   input  wire  [3:0]   req_tuser,
   // byte_value[7:0], column[11:8], row[12], number[44:13], digit_count[48:45]
   input  wire  [55:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // nibble[3:0], strobe_res[4], pre_wait_us[14:5], post_wait_us[29:15]
   output logic [31:0]  rsp_tdata,
   // rs_level[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   lcdseq_pkg::op_type push_op, head_op;
   logic push, full, pop, empty;

   // request intake and digit conversion
   lcdseq_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_op    (push_op),
      .full       (full)
   );

   // write queue
   lcdseq_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .head_op (head_op),
      .empty   (empty)
   );

   // nibble output
   lcdseq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_op    (head_op),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - testbench of the 4-bit character lcd nibble sequencer
// drives display requests on the req_ stream and predicts every nibble
// write with its register select, strobe, waits and last flag. each
// accepted rsp_ beat is compared field by field with the oldest predicted
// write. directed tests cover every mode and the corner cases, then a
// random phase runs with and without idling on both sides.
// ---------------------------------------------------------------------------

module tb_top;
   import lcdseq_pkg::*;

   // mode code that the sequencer drops
   localparam logic [2:0] MODE_UNUSED = 3'd7;
   localparam int         DIGIT_LIMIT = 10;
   localparam int         RANDOM_REQUESTS = 109;
   localparam int         DRAIN_CYCLES = 64;

   // one display request
   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  byte_value;
      logic        reg_select;
      logic [3:0]  column;
      logic        row;
      logic [31:0] number;
      logic [3:0]  digit_count;
   } display_request_type;

   // one nibble write on the lcd bus
   typedef struct packed {
      logic [3:0]  nib;
      logic        rs;
      logic        strobe;
      logic [9:0]  pre;
      logic [14:0] post;
      logic        last;
   } lcd_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [3:0]  req_tuser = '0;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   lcd_write_type  pending_writes[$];
   lcd_write_type  new_writes[$];
   lcd_write_type  got_write;
   lcd_write_type  want_write;
   int             fail_count = 0;
   bit             idling_on = 1'b1;

   char_lcd_nibble_command_sequencer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // write predictor
   // ------------------------------------------------------------------
   function automatic void add_nibble(input logic [3:0] nib, input logic rs,
                                      input logic strobe, input logic [9:0] pre,
                                      input logic [14:0] post);
      lcd_write_type w;
      w.nib    = nib;
      w.rs     = rs;
      w.strobe = strobe;
      w.pre    = pre;
      w.post   = post;
      w.last   = 1'b0;
      new_writes.push_back(w);
   endfunction

   // high nibble first with the hold wait, the low nibble carries the given wait
   function automatic void add_byte(input logic [7:0] b, input logic rs,
                                    input logic [9:0] pre, input logic [14:0] post_lo);
      add_nibble(b[7:4], rs, 1'b1, pre, HOLD_US);
      add_nibble(b[3:0], rs, 1'b1, 10'd0, post_lo);
   endfunction

   function automatic void add_cursor_move(input logic [3:0] column, input logic row);
      logic [7:0] addr;
      addr = (row ? LINE1_ADDR : LINE0_ADDR) + {4'b0000, column};
      add_byte(addr, 1'b0, GOTO_PRE_US, LONG_US);
   endfunction

   // expands a request into its writes, returns how many
   function automatic int predict_writes(input display_request_type r);
      int            count;
      logic [31:0]   value;
      logic [3:0]    digits [DIGIT_LIMIT];
      lcd_write_type w;
      new_writes.delete();
      case (r.mode)
         MODE_INIT: begin
            add_nibble(4'h0, 1'b0, 1'b0, 10'd0, POWER_UP_US);
            add_nibble(WAKE_NIB_8BIT[3:0], 1'b0, 1'b1, 10'd0, WAKE1_US);
            add_nibble(WAKE_NIB_4BIT[3:0], 1'b0, 1'b1, 10'd0, WAKE2_US);
            add_byte(CMD_FUNC_SET, 1'b0, 10'd0, HOLD_US);
            add_byte(CMD_DISPLAY_ON, 1'b0, 10'd0, HOLD_US);
            add_byte(CMD_CLEAR, 1'b0, 10'd0, LONG_US);
            add_byte(CMD_ENTRY_MODE, 1'b0, 10'd0, HOLD_US);
         end
         MODE_CLEAR: add_byte(CMD_CLEAR, 1'b0, 10'd0, LONG_US);
         MODE_SEND: add_byte(r.byte_value, r.reg_select, 10'd0, HOLD_US);
         MODE_GOTO: add_cursor_move(r.column, r.row);
         MODE_NUMBER: begin
            // too many digits saturates, leading zeros are kept
            count = (r.digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(r.digit_count);
            value = r.number;
            for (int i = 0; i < count; i++) begin
               digits[i] = 4'(value % 10);
               value     = value / 10;
            end
            for (int i = count - 1; i >= 0; i--)
               add_byte(ASCII_ZERO + {4'b0000, digits[i]}, 1'b1, 10'd0, HOLD_US);
         end
         MODE_BLINK: begin
            add_cursor_move(r.column, r.row);
            add_byte(CMD_CURSOR_BLINK, 1'b0, 10'd0, HOLD_US);
         end
         MODE_STEADY: begin
            add_cursor_move(r.column, r.row);
            add_byte(CMD_CURSOR_STEADY, 1'b0, 10'd0, HOLD_US);
         end
         default: ;
      endcase
      if (new_writes.size() > 0) begin
         w = new_writes.pop_back();
         w.last = 1'b1;
         new_writes.push_back(w);
      end
      foreach (new_writes[i]) pending_writes.push_back(new_writes[i]);
      return new_writes.size();
   endfunction

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------
   task automatic send_request(input display_request_type r, output int writes);
      while (idling_on && $urandom_range(0, 99) < 13) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = {r.reg_select, r.mode};
      req_tdata  = {7'b0, r.digit_count, r.number, r.row, r.column, r.byte_value};
      do @(posedge clock); while (!req_tready);
      writes = predict_writes(r);
      @(negedge clock);
   endtask

   function automatic display_request_type make_request(input logic [2:0] mode,
                                                        input logic [7:0] byte_value,
                                                        input logic reg_select,
                                                        input logic [3:0] column,
                                                        input logic row,
                                                        input logic [31:0] number,
                                                        input logic [3:0] digit_count);
      display_request_type r;
      r.mode        = mode;
      r.byte_value  = byte_value;
      r.reg_select  = reg_select;
      r.column      = column;
      r.row         = row;
      r.number      = number;
      r.digit_count = digit_count;
      return r;
   endfunction

   // random request, mostly well formed with small digit counts
   function automatic display_request_type random_request();
      display_request_type r;
      r.mode        = ($urandom_range(0, 99) < 4) ? MODE_UNUSED : 3'($urandom_range(0, 6));
      r.byte_value  = 8'($urandom);
      r.reg_select  = 1'($urandom);
      r.column      = 4'($urandom);
      r.row         = 1'($urandom);
      r.number      = $urandom;
      r.digit_count = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 4))
                                                   : 4'($urandom_range(0, 15));
      return r;
   endfunction

   // ------------------------------------------------------------------
   // result side: random backpressure and checking
   // ------------------------------------------------------------------
   always @(negedge clock)
      rsp_tready = !(idling_on && $urandom_range(0, 99) < 13);

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_write.nib    = rsp_tdata[3:0];
         got_write.rs     = rsp_tuser;
         got_write.strobe = rsp_tdata[4];
         got_write.pre    = rsp_tdata[14:5];
         got_write.post   = rsp_tdata[29:15];
         got_write.last   = rsp_tlast;
         if (pending_writes.size() == 0) begin
            note_failure($sformatf(
               "expected none actual nib=%h rs=%b strobe=%b pre=%0d post=%0d last=%b",
               got_write.nib, got_write.rs, got_write.strobe,
               got_write.pre, got_write.post, got_write.last));
         end else begin
            want_write = pending_writes.pop_front();
            if (got_write.nib !== want_write.nib || got_write.rs !== want_write.rs ||
                got_write.strobe !== want_write.strobe || got_write.pre !== want_write.pre ||
                got_write.post !== want_write.post || got_write.last !== want_write.last)
               note_failure({$sformatf(
                                "expected nib=%h rs=%b strobe=%b pre=%0d post=%0d last=%b",
                                want_write.nib, want_write.rs, want_write.strobe,
                                want_write.pre, want_write.post, want_write.last),
                             $sformatf(
                                " actual nib=%h rs=%b strobe=%b pre=%0d post=%0d last=%b",
                                got_write.nib, got_write.rs, got_write.strobe,
                                got_write.pre, got_write.post, got_write.last)});
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_init_and_clear();
      int n;
      send_request(make_request(MODE_INIT, 8'h00, 1'b0, 4'h0, 1'b0, 32'd0, 4'd0), n);
      send_request(make_request(MODE_CLEAR, 8'hFF, 1'b1, 4'hF, 1'b1, 32'hFFFF_FFFF, 4'hF), n);
   endtask

   task automatic test_send_byte();
      int n;
      send_request(make_request(MODE_SEND, 8'h00, 1'b0, 4'h0, 1'b0, 32'd0, 4'd0), n);
      send_request(make_request(MODE_SEND, 8'hFF, 1'b1, 4'h0, 1'b0, 32'd0, 4'd0), n);
      send_request(make_request(MODE_SEND, 8'hA5, 1'b0, 4'h0, 1'b0, 32'd0, 4'd0), n);
      send_request(make_request(MODE_SEND, 8'h5A, 1'b1, 4'h0, 1'b0, 32'd0, 4'd0), n);
   endtask

   task automatic test_cursor_moves();
      int n;
      send_request(make_request(MODE_GOTO, 8'h00, 1'b0, 4'h0, 1'b0, 32'd0, 4'd0), n);
      send_request(make_request(MODE_GOTO, 8'h00, 1'b0, 4'hF, 1'b1, 32'd0, 4'd0), n);
      send_request(make_request(MODE_BLINK, 8'h00, 1'b0, 4'h5, 1'b0, 32'd0, 4'd0), n);
      send_request(make_request(MODE_BLINK, 8'h00, 1'b0, 4'hF, 1'b1, 32'd0, 4'd0), n);
      send_request(make_request(MODE_STEADY, 8'h00, 1'b0, 4'h0, 1'b1, 32'd0, 4'd0), n);
      send_request(make_request(MODE_STEADY, 8'h00, 1'b0, 4'hA, 1'b0, 32'd0, 4'd0), n);
   endtask

   task automatic test_number_print();
      int n;
      send_request(make_request(MODE_NUMBER, 8'h00, 1'b0, 4'h0, 1'b0, 32'd0, 4'd1), n);
      send_request(make_request(MODE_NUMBER, 8'h00, 1'b0, 4'h0, 1'b0, 32'hFFFF_FFFF, 4'd10), n);
      // digits above the limit saturate
      send_request(make_request(MODE_NUMBER, 8'h00, 1'b0, 4'h0, 1'b0, 32'd1234567890, 4'd15), n);
      send_request(make_request(MODE_NUMBER, 8'h00, 1'b0, 4'h0, 1'b0, 32'd987654, 4'd3), n);
      // leading zeros kept
      send_request(make_request(MODE_NUMBER, 8'h00, 1'b0, 4'h0, 1'b0, 32'd7, 4'd4), n);
      // zero digits gives nothing
      send_request(make_request(MODE_NUMBER, 8'h00, 1'b0, 4'h0, 1'b0, 32'd42, 4'd0), n);
      send_request(make_request(MODE_NUMBER, 8'h00, 1'b0, 4'h0, 1'b0, 32'd99, 4'd2), n);
   endtask

   task automatic test_unused_mode();
      int n;
      send_request(make_request(MODE_UNUSED, 8'hFF, 1'b1, 4'hF, 1'b1, 32'hFFFF_FFFF, 4'hF), n);
      send_request(make_request(MODE_SEND, 8'h3C, 1'b1, 4'h0, 1'b0, 32'd0, 4'd0), n);
   endtask

   task automatic test_random_mix();
      int n;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         // middle stretch runs with no idling on either side
         idling_on = !(i >= 30 && i < 70);
         send_request(random_request(), n);
      end
      idling_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_init_and_clear();
      test_send_byte();
      test_cursor_moves();
      test_number_print();
      test_unused_mode();
      test_random_mix();
      req_tvalid = 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("char_lcd_nibble_command_sequencer_core verification clean");
      else
         $display("char_lcd_nibble_command_sequencer_core verification failed");
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("char_lcd_nibble_command_sequencer_core verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lcdseq_pkg.sv
hw/rtl/lcdseq_fifo.sv
hw/rtl/lcdseq_front.sv
hw/rtl/lcdseq_back.sv
hw/rtl/char_lcd_nibble_command_sequencer_core.sv
verif/tb_top.sv
